// ===== src/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the page-table translator
// Field widths, parameter defaults and the control words passed between the
// sequencer, the TLB and the page-table store.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  localparam int ADDR_BITS    = 16;
  localparam int OFFSET_BITS  = 8;
  localparam int PAGE_BITS    = 8;
  localparam int FRAME_BITS   = 8;
  localparam int FRAME_LIMIT  = 256;
  localparam int CFG_BITS     = 9;
  localparam int COUNT_BITS   = 32;

  localparam int DEF_TLB_ENTRIES = 16;
  localparam int DEF_PAGE_COUNT  = 256;
  localparam int DEF_MAX_FRAMES  = 256;

  localparam logic [CFG_BITS-1:0] FRAME_COUNT_RESET = 9'd128;

  // Command to the TLB: one compare key shared by lookup and invalidation.
  typedef struct packed {
    logic                  insert;
    logic                  drop;
    logic [PAGE_BITS-1:0]  key;
    logic [PAGE_BITS-1:0]  ins_page;
    logic [FRAME_BITS-1:0] ins_frame;
  } tpt_tlb_cmd_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } tpt_tlb_rsp_t;

  // Update to the page table and frame owner store on a fault.
  typedef struct packed {
    logic                  commit;
    logic                  evict;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic [PAGE_BITS-1:0]  drop_page;
  } tpt_ptab_upd_t;

endpackage

`default_nettype wire

// ===== src/tpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tpt_tlb: fully associative TLB with FIFO fill
// One bank of tag comparators serves both the lookup and the invalidation of
// an evicted page; the lowest matching entry wins.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_tlb #(
  parameter int TLB_ENTRIES = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire tpt_pkg::tpt_tlb_cmd_t cmd,
  output tpt_pkg::tpt_tlb_rsp_t rsp
);
  import tpt_pkg::*;

  localparam int TIDX = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [PAGE_BITS-1:0]  tag  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] fnum [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [TLB_ENTRIES-1:0] valid_next;
  logic [TIDX-1:0]        fill_ptr;

  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_ENTRIES-1:0] first;
  logic [FRAME_BITS-1:0]  sel_frame;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = valid[i] && (tag[i] == cmd.key);
    end
  end

  // isolate lowest set bit
  assign first = match & (~match + TLB_ENTRIES'(1));

  always_comb begin
    sel_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (first[i]) begin
        sel_frame = sel_frame | fnum[i];
      end
    end
  end

  always_comb begin
    rsp.hit   = |match;
    rsp.frame = sel_frame;
  end

  // Drop matching entries first, then set the slot being filled.
  always_comb begin
    valid_next = valid;
    if (cmd.drop) begin
      valid_next = valid_next & ~match;
    end
    if (cmd.insert) begin
      valid_next[fill_ptr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fill_ptr <= '0;
    end else begin
      valid <= valid_next;
      if (cmd.insert) begin
        if (fill_ptr == TIDX'(TLB_ENTRIES - 1)) begin
          fill_ptr <= '0;
        end else begin
          fill_ptr <= fill_ptr + TIDX'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      tag[fill_ptr]  <= cmd.ins_page;
      fnum[fill_ptr] <= cmd.ins_frame;
    end
  end

endmodule

`default_nettype wire

// ===== src/tpt_ptab.sv =====
// ----------------------------------------------------------------------------
// tpt_ptab: page table and frame owner store
// Page-to-frame and frame-to-page memories with registered reads, plus the
// resident and owned bits kept in flops that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_ptab #(
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_SLOTS = 256
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [tpt_pkg::PAGE_BITS-1:0]       page,
  input  wire  [tpt_pkg::FRAME_BITS-1:0]      owner_rd_frame,
  input  wire  [tpt_pkg::FRAME_BITS-1:0]      check_frame,
  input  wire tpt_pkg::tpt_ptab_upd_t         upd,
  output logic [tpt_pkg::FRAME_BITS-1:0]      map_frame,
  output logic                                resident,
  output logic [tpt_pkg::PAGE_BITS-1:0]       owner_page,
  output logic                                owned
);
  import tpt_pkg::*;

  localparam int PIDX = $clog2(PAGE_COUNT);
  localparam int FIDX = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  logic [FRAME_BITS-1:0] map_mem   [PAGE_COUNT];
  logic [PAGE_BITS-1:0]  owner_mem [FRAME_SLOTS];
  logic [PAGE_COUNT-1:0]  resident_bits;
  logic [PAGE_COUNT-1:0]  resident_next;
  logic [FRAME_SLOTS-1:0] owned_bits;
  logic [FRAME_SLOTS-1:0] owned_next;

  always_ff @(posedge clk) begin
    map_frame  <= map_mem[page[PIDX-1:0]];
    owner_page <= owner_mem[owner_rd_frame[FIDX-1:0]];
    if (upd.commit) begin
      map_mem[upd.page[PIDX-1:0]]    <= upd.frame;
      owner_mem[upd.frame[FIDX-1:0]] <= upd.page;
    end
  end

  assign resident = resident_bits[page[PIDX-1:0]];
  assign owned    = owned_bits[check_frame[FIDX-1:0]];

  // Clear the evicted page before marking the new one resident.
  always_comb begin
    resident_next = resident_bits;
    owned_next    = owned_bits;
    if (upd.commit) begin
      if (upd.evict) begin
        resident_next[upd.drop_page[PIDX-1:0]] = 1'b0;
      end
      resident_next[upd.page[PIDX-1:0]] = 1'b1;
      owned_next[upd.frame[FIDX-1:0]]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident_bits <= '0;
      owned_bits    <= '0;
    end else begin
      resident_bits <= resident_next;
      owned_bits    <= owned_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator: demand-paging translator with TLB and FIFO frames
// Splits a logical address into page and offset, looks the page up in the
// TLB, falls back to the page table, and allocates or replaces a frame on a
// page fault. Reports flags and wrapping totals with each result word.
// ----------------------------------------------------------------------------
// Flow: a TLB hit passes S_IDLE, S_LOOK and S_DONE into the output register;
//   a TLB miss also passes S_FILL (resident page) or S_FAULT (page fault);
//   S_DONE holds while the previous word is unaccepted in the output register.
// Occupancy: one word at a time, accepted only in S_IDLE; the sequencer walks
//   it through the shared tag compare and the registered memory reads.
// Reset: rst clears TLB valid bits, resident and owned bits, all pointers and
//   totals, and sets the frame count to 128. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tpt_pkg::DEF_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tpt_pkg::DEF_PAGE_COUNT,
  parameter int MAX_FRAMES  = tpt_pkg::DEF_MAX_FRAMES
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tpt_pkg::CFG_BITS-1:0]       frame_cap,
  // input channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [tpt_pkg::ADDR_BITS-1:0]      virt_addr,
  // output channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tpt_pkg::ADDR_BITS-1:0]      phys_addr,
  output logic                               tlb_hit,
  output logic                               page_fault,
  output logic [tpt_pkg::PAGE_BITS-1:0]      fault_page,
  output logic                               evicted,
  output logic [tpt_pkg::PAGE_BITS-1:0]      evicted_page,
  output logic [tpt_pkg::COUNT_BITS-1:0]     hit_total,
  output logic [tpt_pkg::COUNT_BITS-1:0]     fault_total,
  output logic [tpt_pkg::COUNT_BITS-1:0]     address_total
);
  import tpt_pkg::*;

  // Frames are 8 bits wide, so at most 256 slots regardless of MAX_FRAMES.
  localparam int FRAME_SLOTS = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;
  localparam logic [CFG_BITS-1:0] SLOT_MAX = CFG_BITS'(FRAME_SLOTS);
  localparam logic [CFG_BITS-1:0] ACTIVE_RESET =
    (FRAME_COUNT_RESET == '0)      ? CFG_BITS'(1) :
    (FRAME_COUNT_RESET > SLOT_MAX) ? SLOT_MAX     : FRAME_COUNT_RESET;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_FILL  = 5'b00100,
    S_FAULT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Page number modulo PAGE_COUNT, resolved at elaboration into a table.
  logic [PAGE_BITS-1:0] page_lut [1 << PAGE_BITS];
  for (genvar g = 0; g < (1 << PAGE_BITS); g++) begin : g_page_lut
    assign page_lut[g] = PAGE_BITS'(g % PAGE_COUNT);
  end

  // Item registers
  logic [PAGE_BITS-1:0]   page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic                   hit_q;
  logic                   fault_q;
  logic                   ev_q;
  logic [PAGE_BITS-1:0]   evp_q;

  // Frame allocator
  logic [CFG_BITS-1:0]   active_n;
  logic [CFG_BITS-1:0]   free_ptr;
  logic [FRAME_BITS-1:0] victim_ptr;
  logic [FRAME_BITS-1:0] alloc_frame;
  logic                  use_free;
  logic [CFG_BITS-1:0]   alloc_inc;

  // Counters double as the total outputs
  logic [COUNT_BITS-1:0] hit_counter;
  logic [COUNT_BITS-1:0] fault_counter;
  logic [COUNT_BITS-1:0] address_counter;

  tpt_tlb_cmd_t  tlb_cmd;
  tpt_tlb_rsp_t  tlb_rsp;
  tpt_ptab_upd_t ptab_upd;
  logic [FRAME_BITS-1:0] map_frame;
  logic                  resident;
  logic [PAGE_BITS-1:0]  owner_page;
  logic                  owned;

  logic in_fire;
  logic load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign load      = (state == S_DONE) && (!out_valid || out_ready);

  // Take the free frame while any remain, else the FIFO victim (frame 0 if
  // the victim pointer sits beyond a lowered frame count).
  assign use_free = (free_ptr < active_n);
  always_comb begin
    if (use_free) begin
      alloc_frame = free_ptr[FRAME_BITS-1:0];
    end else if ({1'b0, victim_ptr} < active_n) begin
      alloc_frame = victim_ptr;
    end else begin
      alloc_frame = '0;
    end
  end
  assign alloc_inc = {1'b0, alloc_frame} + CFG_BITS'(1);

  // The compare key is the incoming page during lookup and the owner of the
  // replaced frame while its stale TLB entries are dropped.
  always_comb begin
    tlb_cmd.key       = (state == S_FAULT) ? owner_page : page_q;
    tlb_cmd.drop      = (state == S_FAULT) && owned;
    tlb_cmd.insert    = (state == S_FILL) || (state == S_FAULT);
    tlb_cmd.ins_page  = page_q;
    tlb_cmd.ins_frame = (state == S_FILL) ? map_frame : frame_q;
  end

  always_comb begin
    ptab_upd.commit    = (state == S_FAULT);
    ptab_upd.evict     = owned;
    ptab_upd.page      = page_q;
    ptab_upd.frame     = frame_q;
    ptab_upd.drop_page = owner_page;
  end

  tpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk (clk),
    .rst (rst),
    .cmd (tlb_cmd),
    .rsp (tlb_rsp)
  );

  tpt_ptab #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_ptab (
    .clk            (clk),
    .rst            (rst),
    .page           (page_q),
    .owner_rd_frame (alloc_frame),
    .check_frame    (frame_q),
    .upd            (ptab_upd),
    .map_frame      (map_frame),
    .resident       (resident),
    .owner_page     (owner_page),
    .owned          (owned)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (tlb_rsp.hit) begin
          state_next = S_DONE;
        end else if (resident) begin
          state_next = S_FILL;
        end else begin
          state_next = S_FAULT;
        end
      end
      S_FILL:  state_next = S_DONE;
      S_FAULT: state_next = S_DONE;
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration: store the clamped frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      active_n <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (frame_cap == '0) begin
        active_n <= CFG_BITS'(1);
      end else if (frame_cap > SLOT_MAX) begin
        active_n <= SLOT_MAX;
      end else begin
        active_n <= frame_cap;
      end
    end
  end

  // Allocation pointers advance when the fault is decided
  always_ff @(posedge clk) begin
    if (rst) begin
      free_ptr   <= '0;
      victim_ptr <= '0;
    end else if ((state == S_LOOK) && !tlb_rsp.hit && !resident) begin
      if (use_free) begin
        free_ptr <= free_ptr + CFG_BITS'(1);
      end else if (alloc_inc == active_n) begin
        victim_ptr <= '0;
      end else begin
        victim_ptr <= alloc_inc[FRAME_BITS-1:0];
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_q   <= page_lut[virt_addr[ADDR_BITS-1:OFFSET_BITS]];
      offset_q <= virt_addr[OFFSET_BITS-1:0];
    end
    unique case (state)
      S_LOOK: begin
        hit_q   <= tlb_rsp.hit;
        fault_q <= !tlb_rsp.hit && !resident;
        ev_q    <= 1'b0;
        evp_q   <= '0;
        frame_q <= tlb_rsp.hit ? tlb_rsp.frame : alloc_frame;
      end
      S_FILL: begin
        frame_q <= map_frame;
      end
      S_FAULT: begin
        ev_q  <= owned;
        evp_q <= owned ? owner_page : '0;
      end
      default: begin
      end
    endcase
  end

  // Output register and running totals; hold while the word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      hit_counter     <= '0;
      fault_counter   <= '0;
      address_counter <= '0;
    end else if (load) begin
      out_valid       <= 1'b1;
      hit_counter     <= hit_counter + COUNT_BITS'(hit_q);
      fault_counter   <= fault_counter + COUNT_BITS'(fault_q);
      address_counter <= address_counter + COUNT_BITS'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phys_addr    <= {frame_q, offset_q};
      tlb_hit      <= hit_q;
      page_fault   <= fault_q;
      fault_page   <= fault_q ? page_q : '0;
      evicted      <= ev_q;
      evicted_page <= evp_q;
    end
  end

  assign hit_total     = hit_counter;
  assign fault_total   = fault_counter;
  assign address_total = address_counter;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!evicted || page_fault))
    else $error("eviction reported without a page fault");

  a_hit_not_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("TLB hit and page fault on the same word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    load |=> (address_total == $past(address_total) + COUNT_BITS'(1)))
    else $error("address total did not advance by one");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_ptr <= SLOT_MAX)
    else $error("free frame pointer beyond frame slots");

endmodule

`default_nettype wire
